@@ rtl/core/usbeb_pkg.sv @@
`default_nettype none

package usbeb_pkg;

  localparam int NUM_ENDPOINTS = 8;
  localparam int MAX_PACKET    = 64;
  localparam int EP_W          = $clog2(NUM_ENDPOINTS);
  localparam int MASK_W        = 8;
  localparam int REQ_W         = 10;
  localparam int LEN_W         = 7;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 24;

  // configuration register indexes
  localparam logic CFG_TX_DOUBLE = 1'b0;
  localparam logic CFG_RX_DOUBLE = 1'b1;

  typedef enum logic [2:0] {
    OP_CONFIGURE = 3'd0,
    OP_SUBMIT    = 3'd1,
    OP_TX_DONE   = 3'd2,
    OP_RX_DONE   = 3'd3,
    OP_PAUSE     = 3'd4,
    OP_UNPAUSE   = 3'd5,
    OP_RESET_ALL = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_ARM    = 2'd1,
    ACT_TOGGLE = 2'd2,
    ACT_DEFER  = 2'd3
  } rx_action_e;

  // transmit occupancy codes
  localparam logic [2:0] OCC_SGL_EMPTY = 3'd0;
  localparam logic [2:0] OCC_SGL_FULL  = 3'd1;
  localparam logic [2:0] OCC_DBL_EMPTY = 3'd2;
  localparam logic [2:0] OCC_DBL_ONE   = 3'd3;
  localparam logic [2:0] OCC_DBL_TWO   = 3'd4;

  // receive mode codes
  localparam logic [2:0] RX_SGL_READY   = 3'd0;
  localparam logic [2:0] RX_SGL_PAUSED  = 3'd1;
  localparam logic [2:0] RX_DBL_READY0  = 3'd2;
  localparam logic [2:0] RX_DBL_READY1  = 3'd3;
  localparam logic [2:0] RX_DBL_PAUSED0 = 3'd4;
  localparam logic [2:0] RX_DBL_PAUSED1 = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]       tx_pending;
    logic [LEN_W-1:0] tx_space;
    logic             force_nak;
    logic [1:0]       buffer_toggles;
    rx_action_e       rx_action;
    logic             buffer_slot;
    logic [LEN_W-1:0] sent_length;
    logic             accepted;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/usb_endpoint_buffer_tracker.sv @@
`default_nettype none

// A request accepted in ST_IDLE moves through ST_EXEC, where its result is registered, to ST_OUT,
// where m_axis_tvalid shows it. The steps are capture, update and result handoff; a new request
// is taken only once the result has been accepted on m_axis_tready, as the controller sequences.
// Reset (rst_ni low, async): all endpoints return to single-buffered, empty, ready,
// no deferred acks; both double-buffer masks clear to zero.
module usb_endpoint_buffer_tracker
  import usbeb_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // op[2:0], endpoint[5:3], is_in[6], request_length[16:7], zero[23:17]
  input  wire  [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // accepted[0], sent_length[7:1], buffer_slot[8], rx_action[10:9],
  // buffer_toggles[12:11], force_nak[13], tx_space[20:14], tx_pending[22:21], zero[23]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire                    cfg_we_i,
  input  wire                    cfg_idx_i,
  input  wire  [MASK_W-1:0]      cfg_data_i
);

  dp_cmd_t cmd;
  result_t result;

  usbeb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  usbeb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result)
  );

  assign m_axis_tdata = {1'b0, result};

endmodule

`default_nettype wire

@@ rtl/core/usbeb_ctrl.sv @@
`default_nettype none

module usbeb_ctrl
  import usbeb_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  wire     out_ready_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/usbeb_dp.sv @@
`default_nettype none

module usbeb_dp
  import usbeb_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  dp_cmd_t                cmd_i,
  input  wire  [IN_TDATA_W-1:0]  in_data_i,
  input  wire                    cfg_we_i,
  input  wire                    cfg_idx_i,
  input  wire  [MASK_W-1:0]      cfg_data_i,
  output result_t                result_o
);

  // captured request
  op_e              op_q;
  logic [EP_W-1:0]  ep_q;
  logic             is_in_q;
  logic [REQ_W-1:0] req_q;

  logic [MASK_W-1:0] tx_mask_q, rx_mask_q;

  logic [2:0] occ_q   [NUM_ENDPOINTS];
  logic [2:0] rxm_q   [NUM_ENDPOINTS];
  logic [1:0] acks_q  [NUM_ENDPOINTS];
  logic       sel_q   [NUM_ENDPOINTS];
  logic [2:0] occ_d   [NUM_ENDPOINTS];
  logic [2:0] rxm_d   [NUM_ENDPOINTS];
  logic [1:0] acks_d  [NUM_ENDPOINTS];
  logic       sel_d   [NUM_ENDPOINTS];

  logic [2:0] occ_cur, rxm_cur, occ_nxt, rxm_nxt;
  logic [1:0] acks_cur, acks_nxt;
  logic       sel_cur, sel_nxt;
  result_t    res;
  result_t    result_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(in_data_i[2:0]);
      ep_q    <= in_data_i[3 +: EP_W];
      is_in_q <= in_data_i[6];
      req_q   <= in_data_i[16:7];
    end
    if (cmd_i.exec) begin
      result_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_mask_q <= '0;
      rx_mask_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TX_DOUBLE) begin
        tx_mask_q <= cfg_data_i;
      end else begin
        rx_mask_q <= cfg_data_i;
      end
    end
  end

  assign occ_cur  = occ_q[ep_q];
  assign rxm_cur  = rxm_q[ep_q];
  assign acks_cur = acks_q[ep_q];
  assign sel_cur  = sel_q[ep_q];

  always_comb begin
    occ_nxt  = occ_cur;
    rxm_nxt  = rxm_cur;
    acks_nxt = acks_cur;
    sel_nxt  = sel_cur;
    res      = '0;
    case (op_q)
      OP_CONFIGURE: begin
        if (is_in_q || ep_q == '0) begin
          occ_nxt = tx_mask_q[ep_q] ? OCC_DBL_EMPTY : OCC_SGL_EMPTY;
          sel_nxt = 1'b0;
        end
        if (!is_in_q) begin
          rxm_nxt  = rx_mask_q[ep_q] ? RX_DBL_READY0 : RX_SGL_READY;
          acks_nxt = 2'd0;
        end
      end
      OP_SUBMIT: begin
        case (occ_cur) inside
          OCC_SGL_EMPTY: begin
            occ_nxt      = OCC_SGL_FULL;
            res.accepted = 1'b1;
          end
          OCC_DBL_EMPTY, OCC_DBL_ONE: begin
            res.buffer_slot = sel_cur;
            sel_nxt         = ~sel_cur;
            occ_nxt         = occ_cur + 3'd1;
            res.accepted    = 1'b1;
          end
          default: ;
        endcase
        if (res.accepted) begin
          res.sent_length = (req_q < REQ_W'(MAX_PACKET)) ? req_q[LEN_W-1:0]
                                                         : LEN_W'(MAX_PACKET);
        end
      end
      OP_TX_DONE: begin
        if (occ_cur inside {OCC_SGL_FULL, OCC_DBL_ONE, OCC_DBL_TWO}) begin
          occ_nxt = occ_cur - 3'd1;
        end
        if ((occ_cur inside {[OCC_DBL_EMPTY:OCC_DBL_TWO]}) && !sel_cur) begin
          res.buffer_slot = 1'b1;
        end
      end
      OP_RX_DONE: begin
        case (rxm_cur) inside
          RX_SGL_READY: begin
            res.rx_action = ACT_ARM;
          end
          [RX_DBL_READY0:RX_DBL_PAUSED1]: begin
            res.buffer_slot = rxm_cur[0];
            if (rxm_cur <= RX_DBL_READY1) begin
              res.rx_action = ACT_TOGGLE;
            end else begin
              res.rx_action = ACT_DEFER;
              if (acks_cur != 2'd3) begin
                acks_nxt = acks_cur + 2'd1;
              end
            end
            rxm_nxt = {rxm_cur[2:1], ~rxm_cur[0]};
          end
          default: ;
        endcase
      end
      OP_PAUSE: begin
        if (!is_in_q) begin
          case (rxm_cur) inside
            RX_SGL_READY: begin
              rxm_nxt       = RX_SGL_PAUSED;
              res.force_nak = 1'b1;
            end
            RX_DBL_READY0, RX_DBL_READY1: begin
              rxm_nxt = rxm_cur + 3'd2;
            end
            default: ;
          endcase
        end
      end
      OP_UNPAUSE: begin
        if (!is_in_q) begin
          case (rxm_cur) inside
            RX_SGL_PAUSED: begin
              rxm_nxt       = RX_SGL_READY;
              res.rx_action = ACT_ARM;
            end
            RX_DBL_PAUSED0, RX_DBL_PAUSED1: begin
              rxm_nxt            = rxm_cur - 3'd2;
              res.buffer_toggles = acks_cur;
              acks_nxt           = 2'd0;
            end
            default: ;
          endcase
        end
      end
      OP_RESET_ALL: begin
        if (ep_q != '0) begin
          occ_nxt  = OCC_SGL_EMPTY;
          rxm_nxt  = RX_SGL_READY;
          acks_nxt = 2'd0;
          sel_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
    // report reflects the endpoint after the update
    if (occ_nxt inside {OCC_SGL_EMPTY, OCC_DBL_EMPTY, OCC_DBL_ONE}) begin
      res.tx_space = LEN_W'(MAX_PACKET);
    end
    if (occ_nxt inside {OCC_SGL_FULL, OCC_DBL_ONE}) begin
      res.tx_pending = 2'd1;
    end else if (occ_nxt == OCC_DBL_TWO) begin
      res.tx_pending = 2'd2;
    end
  end

  always_comb begin
    for (int e = 0; e < NUM_ENDPOINTS; e++) begin
      occ_d[e]  = occ_q[e];
      rxm_d[e]  = rxm_q[e];
      acks_d[e] = acks_q[e];
      sel_d[e]  = sel_q[e];
      if (cmd_i.exec) begin
        if (op_q == OP_RESET_ALL && e != 0) begin
          occ_d[e]  = OCC_SGL_EMPTY;
          rxm_d[e]  = RX_SGL_READY;
          acks_d[e] = 2'd0;
          sel_d[e]  = 1'b0;
        end else if (ep_q == EP_W'(e)) begin
          occ_d[e]  = occ_nxt;
          rxm_d[e]  = rxm_nxt;
          acks_d[e] = acks_nxt;
          sel_d[e]  = sel_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < NUM_ENDPOINTS; e++) begin
        occ_q[e]  <= OCC_SGL_EMPTY;
        rxm_q[e]  <= RX_SGL_READY;
        acks_q[e] <= 2'd0;
        sel_q[e]  <= 1'b0;
      end
    end else begin
      for (int e = 0; e < NUM_ENDPOINTS; e++) begin
        occ_q[e]  <= occ_d[e];
        rxm_q[e]  <= rxm_d[e];
        acks_q[e] <= acks_d[e];
        sel_q[e]  <= sel_d[e];
      end
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

@@ sim/usbeb_tracker_checker.sv @@
`timescale 1ns / 100ps

module usbeb_tracker_checker
  import usbeb_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    req_valid_i,
  input  wire                    req_ready_i,
  input  wire [IN_TDATA_W-1:0]   req_data_i,
  input  wire                    res_valid_i,
  input  wire                    res_ready_i,
  input  wire [OUT_TDATA_W-1:0]  res_data_i,
  input  wire                    cfg_we_i,
  input  wire                    cfg_idx_i,
  input  wire [MASK_W-1:0]       cfg_data_i,
  output int                     mismatches_o,
  output int                     awaiting_o
);

  logic [MASK_W-1:0] tx_dbl_mask;
  logic [MASK_W-1:0] rx_dbl_mask;
  logic [2:0]        tx_occ    [NUM_ENDPOINTS];
  logic [2:0]        rx_mode   [NUM_ENDPOINTS];
  logic [1:0]        held_acks [NUM_ENDPOINTS];
  logic              tx_sel    [NUM_ENDPOINTS];

  result_t awaited_results[$];
  result_t want;
  result_t got;
  int      mismatches = 0;

  function automatic result_t endpoint_op_result(logic [2:0] op, logic [EP_W-1:0] ep,
                                                 logic is_in, logic [REQ_W-1:0] len);
    result_t    r;
    logic [2:0] occ;
    logic [2:0] rxs;
    r   = '0;
    occ = tx_occ[ep];
    rxs = rx_mode[ep];
    case (op)
      OP_CONFIGURE: begin
        // OUT configure on endpoint 0 sets up both directions
        if (is_in || ep == 0) begin
          tx_occ[ep] = tx_dbl_mask[ep] ? OCC_DBL_EMPTY : OCC_SGL_EMPTY;
          tx_sel[ep] = 1'b0;
        end
        if (!is_in) begin
          rx_mode[ep]   = rx_dbl_mask[ep] ? RX_DBL_READY0 : RX_SGL_READY;
          held_acks[ep] = 2'd0;
        end
      end
      OP_SUBMIT: begin
        if (occ == OCC_SGL_EMPTY) begin
          tx_occ[ep] = OCC_SGL_FULL;
          r.accepted = 1'b1;
        end else if (occ == OCC_DBL_EMPTY || occ == OCC_DBL_ONE) begin
          r.buffer_slot = tx_sel[ep];
          tx_sel[ep]    = ~tx_sel[ep];
          tx_occ[ep]    = occ + 3'd1;
          r.accepted    = 1'b1;
        end
        if (r.accepted)
          r.sent_length = (len < MAX_PACKET) ? len[LEN_W-1:0] : LEN_W'(MAX_PACKET);
      end
      OP_TX_DONE: begin
        if (occ == OCC_SGL_FULL || occ == OCC_DBL_ONE || occ == OCC_DBL_TWO)
          tx_occ[ep] = occ - 3'd1;
        // slot is reported even when nothing was queued
        if (occ >= OCC_DBL_EMPTY && occ <= OCC_DBL_TWO && !tx_sel[ep])
          r.buffer_slot = 1'b1;
      end
      OP_RX_DONE: begin
        if (rxs == RX_SGL_READY) begin
          r.rx_action = ACT_ARM;
        end else if (rxs >= RX_DBL_READY0 && rxs <= RX_DBL_PAUSED1) begin
          r.buffer_slot = rxs[0];
          if (rxs <= RX_DBL_READY1) begin
            r.rx_action = ACT_TOGGLE;
          end else begin
            r.rx_action = ACT_DEFER;
            if (held_acks[ep] != 2'd3)
              held_acks[ep] = held_acks[ep] + 2'd1;
          end
          rx_mode[ep] = rxs ^ 3'd1;
        end
      end
      OP_PAUSE: begin
        if (!is_in) begin
          if (rxs == RX_SGL_READY) begin
            rx_mode[ep] = RX_SGL_PAUSED;
            r.force_nak = 1'b1;
          end else if (rxs == RX_DBL_READY0 || rxs == RX_DBL_READY1) begin
            rx_mode[ep] = rxs + 3'd2;
          end
        end
      end
      OP_UNPAUSE: begin
        if (!is_in) begin
          if (rxs == RX_SGL_PAUSED) begin
            rx_mode[ep] = RX_SGL_READY;
            r.rx_action = ACT_ARM;
          end else if (rxs == RX_DBL_PAUSED0 || rxs == RX_DBL_PAUSED1) begin
            rx_mode[ep]      = rxs - 3'd2;
            r.buffer_toggles = held_acks[ep];
            held_acks[ep]    = 2'd0;
          end
        end
      end
      OP_RESET_ALL: begin
        for (int e = 1; e < NUM_ENDPOINTS; e++) begin
          tx_occ[e]    = OCC_SGL_EMPTY;
          rx_mode[e]   = RX_SGL_READY;
          held_acks[e] = 2'd0;
          tx_sel[e]    = 1'b0;
        end
      end
      default: ;
    endcase
    occ = tx_occ[ep];
    r.tx_space = (occ == OCC_SGL_EMPTY || occ == OCC_DBL_EMPTY || occ == OCC_DBL_ONE) ?
                 LEN_W'(MAX_PACKET) : '0;
    if (occ == OCC_SGL_FULL || occ == OCC_DBL_ONE)
      r.tx_pending = 2'd1;
    else if (occ == OCC_DBL_TWO)
      r.tx_pending = 2'd2;
    return r;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_dbl_mask = '0;
      rx_dbl_mask = '0;
      for (int e = 0; e < NUM_ENDPOINTS; e++) begin
        tx_occ[e]    = OCC_SGL_EMPTY;
        rx_mode[e]   = RX_SGL_READY;
        held_acks[e] = 2'd0;
        tx_sel[e]    = 1'b0;
      end
      awaited_results.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        got = result_t'(res_data_i[$bits(result_t)-1:0]);
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, res_data_i);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("sent_length", want.sent_length, got.sent_length);
          check_field("buffer_slot", want.buffer_slot, got.buffer_slot);
          check_field("rx_action", want.rx_action, got.rx_action);
          check_field("buffer_toggles", want.buffer_toggles, got.buffer_toggles);
          check_field("force_nak", want.force_nak, got.force_nak);
          check_field("tx_space", want.tx_space, got.tx_space);
          check_field("tx_pending", want.tx_pending, got.tx_pending);
          check_field("pad bits", 0, res_data_i[OUT_TDATA_W-1:$bits(result_t)]);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TX_DOUBLE)
          tx_dbl_mask = cfg_data_i;
        else
          rx_dbl_mask = cfg_data_i;
      end
      if (req_valid_i && req_ready_i)
        awaited_results.push_back(endpoint_op_result(req_data_i[2:0], req_data_i[5:3],
                                                     req_data_i[6], req_data_i[16:7]));
    end
    mismatches_o = mismatches;
    awaiting_o   = awaited_results.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import usbeb_pkg::*;

  localparam logic [2:0] OP_UNDEFINED = 3'd7;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_valid;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data;
  logic                   m_valid;
  logic                   m_ready;
  logic [OUT_TDATA_W-1:0] m_data;
  logic                   cfg_we;
  logic                   cfg_idx;
  logic [MASK_W-1:0]      cfg_data;
  int                     mismatches;
  int                     awaiting;
  bit                     quiet;

  usb_endpoint_buffer_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  usbeb_tracker_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_valid),
    .req_ready_i  (s_ready),
    .req_data_i   (s_data),
    .res_valid_i  (m_valid),
    .res_ready_i  (m_ready),
    .res_data_i   (m_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .awaiting_o   (awaiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("** usb_endpoint_buffer_tracker: FAILED **");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // result side: runs of ready and stalls, always ready while quiet
  initial begin
    int run;
    run = 0;
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        m_ready = 1'b1;
        run = 0;
      end else if (run == 0) begin
        m_ready = ($urandom_range(0, 2) != 0);
        run = m_ready ? $urandom_range(1, 30) : pick_gap() + 1;
      end else begin
        run--;
      end
    end
  end

  task automatic send_request(input logic [2:0] op, input logic [EP_W-1:0] ep,
                              input logic is_in, input logic [REQ_W-1:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_data  = {7'd0, len, is_in, ep, op};
    s_valid = 1'b1;
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_valid = 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [MASK_W-1:0] val);
    cfg_idx  = idx;
    cfg_data = val;
    cfg_we   = 1'b1;
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return OP_SUBMIT;
    if (r < 45) return OP_TX_DONE;
    if (r < 65) return OP_RX_DONE;
    if (r < 73) return OP_PAUSE;
    if (r < 81) return OP_UNPAUSE;
    if (r < 89) return OP_CONFIGURE;
    if (r < 93) return OP_RESET_ALL;
    if (r < 96) return OP_UNDEFINED;
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [REQ_W-1:0] pick_len();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return REQ_W'($urandom_range(MAX_PACKET - 1, MAX_PACKET + 1));
      2: return '1;
      default: return REQ_W'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    logic [MASK_W-1:0] tx_masks [6];
    logic [MASK_W-1:0] rx_masks [6];
    logic [EP_W-1:0]   focus;
    s_valid  = 1'b0;
    s_data   = '0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_TX_DOUBLE;
    cfg_data = '0;
    quiet    = 1'b1;
    rst_ni   = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: endpoint 0 single, endpoint 1 double in both directions
    write_reg(CFG_TX_DOUBLE, 8'h02);
    write_reg(CFG_RX_DOUBLE, 8'h02);
    quiet = 1'b0;
    send_request(OP_CONFIGURE, 3'd0, 1'b0, '0);
    send_request(OP_CONFIGURE, 3'd1, 1'b1, '0);
    send_request(OP_CONFIGURE, 3'd1, 1'b0, '0);
    send_request(OP_SUBMIT,    3'd0, 1'b1, '1);
    send_request(OP_SUBMIT,    3'd0, 1'b0, '0);     // busy
    send_request(OP_TX_DONE,   3'd0, 1'b1, '0);
    send_request(OP_TX_DONE,   3'd0, 1'b1, '0);     // empty
    send_request(OP_SUBMIT,    3'd1, 1'b1, 10'd63);
    send_request(OP_SUBMIT,    3'd1, 1'b1, 10'd64);
    send_request(OP_SUBMIT,    3'd1, 1'b1, 10'd65); // both buffers full
    send_request(OP_TX_DONE,   3'd1, 1'b0, '0);
    send_request(OP_TX_DONE,   3'd1, 1'b0, '0);
    send_request(OP_TX_DONE,   3'd1, 1'b0, '0);
    send_request(OP_RX_DONE,   3'd0, 1'b1, '0);
    send_request(OP_PAUSE,     3'd0, 1'b0, '0);
    send_request(OP_UNPAUSE,   3'd0, 1'b0, '0);
    send_request(OP_PAUSE,     3'd1, 1'b1, '0);     // IN pause does nothing
    send_request(OP_RX_DONE,   3'd1, 1'b0, '0);
    send_request(OP_PAUSE,     3'd1, 1'b0, '0);
    repeat (4) send_request(OP_RX_DONE, 3'd1, 1'b1, '0); // ack count saturates
    send_request(OP_UNPAUSE,   3'd1, 1'b0, '0);
    send_request(OP_UNDEFINED, 3'd1, 1'b0, '1);
    send_request(OP_RESET_ALL, 3'd7, 1'b1, '0);
    send_request(OP_SUBMIT,    3'd7, 1'b0, 10'h2AA);

    tx_masks = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
    rx_masks = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
    for (int p = 3; p < 6; p++) begin
      tx_masks[p] = MASK_W'($urandom_range(0, 255));
      rx_masks[p] = MASK_W'($urandom_range(0, 255));
    end

    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(CFG_TX_DOUBLE, tx_masks[p]);
      write_reg(CFG_RX_DOUBLE, rx_masks[p]);
      for (int e = 0; e < NUM_ENDPOINTS; e++) begin
        send_request(OP_CONFIGURE, EP_W'(e), 1'b1, pick_len());
        send_request(OP_CONFIGURE, EP_W'(e), 1'b0, pick_len());
      end
      focus = '0;
      for (int i = 0; i < 112; i++) begin
        if (i % 45 == 0) begin
          quiet = ($urandom_range(0, 3) == 0);
          focus = EP_W'($urandom_range(0, NUM_ENDPOINTS - 1));
        end
        send_request(pick_op(),
                     $urandom_range(0, 1) ? focus : EP_W'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), pick_len());
      end
    end

    quiet = 1'b0;
    drain();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0)
      $display("** usb_endpoint_buffer_tracker: PASSED **");
    else
      $display("** usb_endpoint_buffer_tracker: FAILED **");
    $finish;
  end

endmodule
